FILE: sv/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the serial bus frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam int DATA_BYTES   = 22;
    localparam int CHAIN_BYTES  = 23;
    localparam int POS_W        = 5;
    localparam int CH_W         = 4;
    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    typedef logic [7:0]           t_byte;
    typedef logic [CHAN_BITS-1:0] t_chan;
    typedef logic [CH_W-1:0]      t_ch_num;
    typedef logic [POS_W-1:0]     t_pos;

    localparam t_byte START_BYTE = 8'h0F;
    localparam t_byte END_BYTE   = 8'h00;

    localparam t_pos  LAST_POS   = t_pos'(FRAME_BYTES - 1);
    localparam t_ch_num LAST_CH  = t_ch_num'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: sv/sfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_if / sfd_chan_if
// Valid/ready channels for received bytes and decoded channel beats.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic           valid;
    logic           ready;
    sfd_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sfd_chan_if;
    logic             valid;
    logic             ready;
    sfd_pkg::t_ch_num channel_number;
    sfd_pkg::t_chan   channel_value;
    logic             lost_flag;
    logic             failsafe_flag;
    logic             last_channel;

    modport source (output valid, output channel_number, output channel_value,
                    output lost_flag, output failsafe_flag, output last_channel,
                    input ready);
    modport sink   (input valid, input channel_number, input channel_value,
                    input lost_flag, input failsafe_flag, input last_channel,
                    output ready);
endinterface

FILE: sv/sfd_byte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_cell
// One byte stage of the frame capture line; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module sfd_byte_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  sfd_pkg::t_byte i_data,
    output sfd_pkg::t_byte o_data
);

    sfd_pkg::t_byte r_data;
    sfd_pkg::t_byte n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: sv/sfd_chan_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_chan_cell
// One channel stage of the output line; loads a decoded value or takes its
// neighbor's value when a beat leaves.
// ----------------------------------------------------------------------------
module sfd_chan_cell (
    input  logic               i_clk,
    input  sfd_pkg::t_cell_ctl i_ctl,
    input  sfd_pkg::t_chan     i_load_value,
    input  sfd_pkg::t_chan     i_next_value,
    output sfd_pkg::t_chan     o_value
);

    sfd_pkg::t_chan r_value;
    sfd_pkg::t_chan n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_load_value;
        end else if (i_ctl.shift) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: sv/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Hunts for the start byte, captures a 25-byte frame in a line of byte cells,
// checks the end byte and unpacks 16 channels of 11 bits into a line of
// channel cells that drains one beat per output handshake.
//
//  Channel  Dir  Beat                      Payload
//  i_byte   in   one received byte         data_byte[7:0]
//  o_chan   out  one decoded channel       channel_number, channel_value,
//                                          lost_flag, failsafe_flag,
//                                          last_channel
//
// One byte is taken per cycle while i_byte.ready holds; it drops only on a
// frame's end byte while earlier channels have not all left, rising again in
// the cycle that the last one leaves. A good frame's end byte loads all 16
// channels together, and they leave at one beat per cycle while o_chan.ready
// holds. Synchronous active-low reset returns to hunting with output empty.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfd_byte_if.sink   i_byte,
    sfd_chan_if.source o_chan
);

    logic                r_collecting;
    logic                n_collecting;
    sfd_pkg::t_pos       r_pos;
    sfd_pkg::t_pos       n_pos;
    logic                r_out_valid;
    logic                n_out_valid;
    sfd_pkg::t_ch_num    r_ch;
    sfd_pkg::t_ch_num    n_ch;
    logic                r_lost;
    logic                n_lost;
    logic                r_failsafe;
    logic                n_failsafe;

    logic                end_byte;
    logic                in_fire;
    logic                out_fire;
    logic                drain_done;
    logic                load;
    logic                shift_in;

    sfd_pkg::t_byte      chain [sfd_pkg::CHAIN_BYTES];
    logic [sfd_pkg::DATA_BYTES*8-1:0] frame_bits;
    sfd_pkg::t_chan      chan_value [sfd_pkg::NUM_CHANNELS];
    sfd_pkg::t_cell_ctl  cell_ctl;

    assign end_byte   = r_collecting && (r_pos == sfd_pkg::LAST_POS);
    assign out_fire   = r_out_valid && o_chan.ready;
    assign drain_done = out_fire && (r_ch == sfd_pkg::LAST_CH);
    assign i_byte.ready = !end_byte || !r_out_valid || drain_done;
    assign in_fire    = i_byte.valid && i_byte.ready;
    assign shift_in   = in_fire && r_collecting && !end_byte;
    assign load       = in_fire && end_byte && (i_byte.data_byte == sfd_pkg::END_BYTE);

    assign cell_ctl.load  = load;
    assign cell_ctl.shift = out_fire;

    // capture line: newest byte enters cell 0
    for (genvar g = 0; g < sfd_pkg::CHAIN_BYTES; g++) begin : g_byte
        sfd_byte_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift_in),
            .i_data  ((g == 0) ? i_byte.data_byte : chain[(g == 0) ? 0 : g-1]),
            .o_data  (chain[g])
        );
    end

    // frame byte k (1..22) sits in cell 23-k once byte 23 is in cell 0
    for (genvar k = 0; k < sfd_pkg::DATA_BYTES; k++) begin : g_bits
        assign frame_bits[8*k +: 8] = chain[sfd_pkg::CHAIN_BYTES - 1 - k];
    end

    // output line: cell 0 drives the beat, others move down on each beat
    for (genvar c = 0; c < sfd_pkg::NUM_CHANNELS; c++) begin : g_chan
        sfd_chan_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_load_value (frame_bits[sfd_pkg::CHAN_BITS*c +: sfd_pkg::CHAN_BITS]),
            .i_next_value ((c == sfd_pkg::NUM_CHANNELS - 1) ? chan_value[c]
                           : chan_value[(c == sfd_pkg::NUM_CHANNELS - 1) ? c : c+1]),
            .o_value      (chan_value[c])
        );
    end

    always_comb begin
        n_collecting = r_collecting;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_ch         = r_ch;
        n_lost       = r_lost;
        n_failsafe   = r_failsafe;

        if (in_fire) begin
            if (!r_collecting) begin
                if (i_byte.data_byte == sfd_pkg::START_BYTE) begin
                    n_collecting = 1'b1;
                    n_pos        = sfd_pkg::t_pos'(1);
                end
            end else if (end_byte) begin
                n_collecting = 1'b0;
                n_pos        = '0;
            end else begin
                n_pos = r_pos + sfd_pkg::t_pos'(1);
            end
        end

        if (out_fire) begin
            n_ch = r_ch + sfd_pkg::t_ch_num'(1);
            if (drain_done) begin
                n_out_valid = 1'b0;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
            n_ch        = '0;
            n_lost      = chain[0][sfd_pkg::LOST_BIT];
            n_failsafe  = chain[0][sfd_pkg::FAILSAFE_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
            r_ch         <= '0;
        end else begin
            r_collecting <= n_collecting;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
            r_ch         <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lost     <= n_lost;
        r_failsafe <= n_failsafe;
    end

    assign o_chan.valid          = r_out_valid;
    assign o_chan.channel_number = r_ch;
    assign o_chan.channel_value  = chan_value[0];
    assign o_chan.lost_flag      = r_lost;
    assign o_chan.failsafe_flag  = r_failsafe;
    assign o_chan.last_channel   = (r_ch == sfd_pkg::LAST_CH);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial bus frame decoder. Received bytes go in
// from a pending queue with random gaps. Frames are mostly well formed with
// random content, mixed with noise, truncated frames and bad end bytes. A
// byte-level frame tracker in the bench works out the 16 channel beats of
// each good frame. The output side stalls at random, and every channel beat
// is checked field by field against the oldest beat that the tracker expects.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_RANDOM_BYTES = 150;
    localparam int STORE_DEPTH      = sfd_pkg::FRAME_BYTES - 1;
    localparam int FLAGS_IDX        = sfd_pkg::FRAME_BYTES - 3;
    localparam int END_IDX          = sfd_pkg::FRAME_BYTES - 2;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 40;

    typedef struct packed {
        sfd_pkg::t_ch_num number;
        sfd_pkg::t_chan   value;
        logic             lost;
        logic             failsafe;
        logic             last;
    } t_chan_beat;

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           byte_valid = 1'b0;
    sfd_pkg::t_byte byte_data  = '0;
    logic           chan_ready = 1'b0;

    sfd_byte_if u_byte_if ();
    sfd_chan_if u_chan_if ();

    assign u_byte_if.valid     = byte_valid;
    assign u_byte_if.data_byte = byte_data;
    assign u_chan_if.ready     = chan_ready;

    sbus_frame_decoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (u_byte_if),
        .o_chan  (u_chan_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Frame tracker state
    logic           trk_collecting = 1'b0;
    sfd_pkg::t_pos  frame_pos = '0;
    sfd_pkg::t_byte frame_bytes [STORE_DEPTH];
    t_chan_beat     expected_chans [$];

    sfd_pkg::t_byte pending_bytes [$];
    sfd_pkg::t_byte frame_payload [sfd_pkg::DATA_BYTES];
    int             errors = 0;
    logic           byte_taken = 1'b0;

    function automatic int gap_len(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    task automatic track_byte(input sfd_pkg::t_byte b);
        sfd_pkg::t_byte                   flags;
        logic [sfd_pkg::DATA_BYTES*8-1:0] bit_stream;
        t_chan_beat                       beat;
        if (!trk_collecting) begin
            if (b == sfd_pkg::START_BYTE) begin
                trk_collecting = 1'b1;
                frame_pos      = sfd_pkg::t_pos'(1);
            end
        end else begin
            frame_bytes[frame_pos - sfd_pkg::t_pos'(1)] = b;
            frame_pos = frame_pos + sfd_pkg::t_pos'(1);
            if (frame_pos == sfd_pkg::t_pos'(sfd_pkg::FRAME_BYTES)) begin
                trk_collecting = 1'b0;
                frame_pos      = '0;
                if (frame_bytes[END_IDX] == sfd_pkg::END_BYTE) begin
                    flags = frame_bytes[FLAGS_IDX];
                    for (int i = 0; i < sfd_pkg::DATA_BYTES; i++) begin
                        bit_stream[i*8 +: 8] = frame_bytes[i];
                    end
                    for (int ch = 0; ch < sfd_pkg::NUM_CHANNELS; ch++) begin
                        beat.number   = sfd_pkg::t_ch_num'(ch);
                        beat.value    = bit_stream[ch*sfd_pkg::CHAN_BITS +: sfd_pkg::CHAN_BITS];
                        beat.lost     = flags[sfd_pkg::LOST_BIT];
                        beat.failsafe = flags[sfd_pkg::FAILSAFE_BIT];
                        beat.last     = (beat.number == sfd_pkg::LAST_CH);
                        expected_chans.push_back(beat);
                    end
                end
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_chan_beat();
        t_chan_beat want;
        if (expected_chans.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual ch %0d value %0d",
                     $time, u_chan_if.channel_number, u_chan_if.channel_value);
            errors++;
        end else begin
            want = expected_chans.pop_front();
            report_field("channel_number", want.number, u_chan_if.channel_number);
            report_field("channel_value", want.value, u_chan_if.channel_value);
            report_field("lost_flag", want.lost, u_chan_if.lost_flag);
            report_field("failsafe_flag", want.failsafe, u_chan_if.failsafe_flag);
            report_field("last_channel", want.last, u_chan_if.last_channel);
        end
    endtask

    // Monitor: sample both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            byte_taken = byte_valid && u_byte_if.ready;
            if (byte_taken) begin
                track_byte(byte_data);
            end
            if (u_chan_if.valid && chan_ready) begin
                check_chan_beat();
            end
        end
    end

    // Byte driver
    int   byte_gap       = 0;
    int   byte_mode_left = 0;
    logic byte_calm      = 1'b0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (!byte_valid || byte_taken) begin
                if (byte_mode_left == 0) begin
                    byte_calm      = ($urandom_range(0, 3) == 0);
                    byte_mode_left = $urandom_range(20, 80);
                end
                if (byte_gap > 0) begin
                    byte_valid <= 1'b0;
                    byte_gap--;
                end else if (pending_bytes.size() > 0) begin
                    byte_valid <= 1'b1;
                    byte_data  <= pending_bytes.pop_front();
                    byte_gap   = gap_len(byte_calm);
                    byte_mode_left--;
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Channel sink with random stalls
    int   stall_left      = 0;
    int   ready_mode_left = 0;
    logic ready_calm      = 1'b0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (ready_mode_left == 0) begin
                ready_calm      = ($urandom_range(0, 3) == 0);
                ready_mode_left = $urandom_range(30, 150);
            end
            ready_mode_left--;
            if (stall_left > 0) begin
                chan_ready <= 1'b0;
                stall_left--;
            end else begin
                chan_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = gap_len(ready_calm);
                end
            end
        end
    end

    task automatic queue_frame(input sfd_pkg::t_byte flags, input sfd_pkg::t_byte tail);
        pending_bytes.push_back(sfd_pkg::START_BYTE);
        for (int i = 0; i < sfd_pkg::DATA_BYTES; i++) begin
            pending_bytes.push_back(frame_payload[i]);
        end
        pending_bytes.push_back(flags);
        pending_bytes.push_back(tail);
    endtask

    task automatic fill_payload(input sfd_pkg::t_byte pattern);
        for (int i = 0; i < sfd_pkg::DATA_BYTES; i++) begin
            frame_payload[i] = pattern;
        end
    endtask

    task automatic fill_payload_random(input logic biased);
        int pick;
        for (int i = 0; i < sfd_pkg::DATA_BYTES; i++) begin
            pick = biased ? $urandom_range(0, 3) : 3;
            case (pick)
                0: frame_payload[i] = 8'h00;
                1: frame_payload[i] = 8'hFF;
                2: frame_payload[i] = sfd_pkg::START_BYTE;
                default: frame_payload[i] = sfd_pkg::t_byte'($urandom);
            endcase
        end
    endtask

    task automatic queue_noise(input int count);
        sfd_pkg::t_byte b;
        for (int i = 0; i < count; i++) begin
            do begin
                b = sfd_pkg::t_byte'($urandom);
            end while (b == sfd_pkg::START_BYTE);
            pending_bytes.push_back(b);
        end
    endtask

    task automatic queue_random_part();
        int             frame_count;
        int             r;
        int             cut;
        sfd_pkg::t_byte tail;
        frame_count = 0;
        while (frame_count < NUM_RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            if (r <= 6) begin
                fill_payload_random(1'b0);
                tail = sfd_pkg::END_BYTE;
                if (r == 6) begin
                    tail = sfd_pkg::t_byte'($urandom_range(1, 255));
                end
                queue_frame(sfd_pkg::t_byte'($urandom), tail);
                frame_count += sfd_pkg::FRAME_BYTES;
            end else if (r == 7) begin
                cut = $urandom_range(1, 6);
                queue_noise(cut);
                frame_count += cut;
            end else if (r == 8) begin
                cut = $urandom_range(1, sfd_pkg::FRAME_BYTES - 2);
                pending_bytes.push_back(sfd_pkg::START_BYTE);
                for (int i = 0; i < cut; i++) begin
                    pending_bytes.push_back(sfd_pkg::t_byte'($urandom));
                end
                frame_count += cut + 1;
            end else begin
                fill_payload_random(1'b1);
                queue_frame(sfd_pkg::t_byte'($urandom), sfd_pkg::END_BYTE);
                frame_count += sfd_pkg::FRAME_BYTES;
            end
        end
    endtask

    initial begin
        int drain;

        // Ignored while hunting
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h0E);
        pending_bytes.push_back(8'h10);
        // All channels at full scale, both flags set
        fill_payload(8'hFF);
        queue_frame(8'h0C, sfd_pkg::END_BYTE);
        // All channels zero, flag bits clear but every other bit set
        fill_payload(8'h00);
        queue_frame(8'hF3, sfd_pkg::END_BYTE);
        // Start bytes inside the frame stay data
        fill_payload(sfd_pkg::START_BYTE);
        queue_frame(8'h04, sfd_pkg::END_BYTE);
        // Bad end byte, then a good frame right behind it
        fill_payload_random(1'b0);
        queue_frame(8'h08, 8'hFF);
        fill_payload_random(1'b0);
        queue_frame(8'h08, sfd_pkg::END_BYTE);

        queue_random_part();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_valid) begin
            @(posedge clk);
        end
        drain = 0;
        while (expected_chans.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        if (expected_chans.size() != 0) begin
            $display("%0t: %0d channel beats expected, actual none", $time,
                     expected_chans.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sbus_frame_decoder.f
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_byte_cell.sv
sv/sfd_chan_cell.sv
sv/sbus_frame_decoder.sv
tb/tb_top.sv
